>>> rtl/core/baro_pressure_temp_compensation_assert.svh
// Assertion macros for the pressure and temperature compensation block.
// Both macros use the enclosing module's clk_i and rst_ni.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define BPTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bptc: assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define BPTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bptc: assertion failed");

`else

`define BPTC_ASSERT(lbl, prop)
`define BPTC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/bptc_pkg.sv
`timescale 1ns / 1ps

package bptc_pkg;

  // Field widths.
  localparam int unsigned AdcW   = 24;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned DtW    = 25;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // Request queue between front and back.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // Compensation constants.
  localparam logic signed [19:0] TempRef      = 20'sd2000;
  localparam logic signed [19:0] TempVeryCold = 20'sd1500;
  localparam logic [5:0] Off2Mul      = 6'd61;
  localparam logic [4:0] Sens2Mul     = 5'd29;
  localparam logic [4:0] Off2ColdMul  = 5'd17;
  localparam logic [3:0] Sens2ColdMul = 4'd9;
  localparam int unsigned TempShift     = 23;
  localparam int unsigned OffShift      = 6;
  localparam int unsigned SensShift     = 7;
  localparam int unsigned Off2Shift     = 4;
  localparam int unsigned T2ColdShift   = 33;
  localparam int unsigned T2WarmShift   = 38;
  localparam int unsigned ProdShift     = 21;
  localparam int unsigned PressShift    = 15;
  localparam int unsigned OffBaseShift  = 17;
  localparam int unsigned SensBaseShift = 16;

  // Division by 100 through a reciprocal multiply.
  localparam logic [6:0]  Hundred       = 7'd100;
  localparam logic [23:0] PressRecip    = 24'd10737419;
  localparam int unsigned PressRecipSh  = 30;
  localparam logic [14:0] TempRecip     = 15'd20972;
  localparam int unsigned TempRecipSh   = 21;
  localparam logic [22:0] PressMax      = 23'd6553599;

  // Register map.
  typedef enum logic [2:0] {
    RegPressSensRef   = 3'd0,
    RegPressOffsetRef = 3'd1,
    RegSensTempCoeff  = 3'd2,
    RegOffsetTempCoeff = 3'd3,
    RegRefTemperature = 3'd4,
    RegTempCoeff      = 3'd5
  } bptc_reg_e;

  // Calibration words C1..C6.
  typedef struct packed {
    logic [CoefW-1:0] c1;
    logic [CoefW-1:0] c2;
    logic [CoefW-1:0] c3;
    logic [CoefW-1:0] c4;
    logic [CoefW-1:0] c5;
    logic [CoefW-1:0] c6;
  } bptc_coef_t;

  // One classified request.
  typedef struct packed {
    logic                  zero;
    logic signed [DtW-1:0] dt;
    logic [AdcW-1:0]       d1;
  } bptc_item_t;

  // Queue status.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [FifoPtrW:0] level;
  } bptc_fifo_stat_t;

endpackage

>>> rtl/core/baro_pressure_temp_compensation.sv
// Pressure and temperature compensation for a 24-bit barometric sensor.
// Requests arrive on the s_axis channel: one raw temperature conversion (D2)
// and one raw pressure conversion (D1). Each request yields exactly one result
// on the m_axis channel: whole millibars, hundredths of a millibar and whole
// degrees C in tdata, and an error flag in tuser for a zero conversion.
// The six calibration words are to be written over the APB port only while no
// request is in flight; the block itself does not enforce this. A front stage
// classifies each request and pushes it into a four-entry queue; a ten-stage
// back pipeline computes the result.
// Throughput is one request per cycle while the receiver does not stall,
// set by the fully pipelined back end. When the receiver stalls, the back
// pipeline holds in place, the queue fills, and s_axis_tready drops once four
// requests wait in it. Reset clears the calibration words to zero, empties
// the queue and drops all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation import bptc_pkg::*; #(
  parameter int unsigned ADC_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // Request channel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // [23:0] temp_adc, [47:24] press_adc
  // Result channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // [15:0] pressure_mbar,
                                             // [22:16] pressure_hundredths,
                                             // [30:23] temperature_c, [31] constant 0
  output logic                m_axis_tuser   // [0] status
);

  bptc_coef_t      coef_q, coef_d;
  logic            cfg_wr;
  bptc_reg_e       reg_idx;
  bptc_item_t      front_item;
  bptc_item_t      fifo_item;
  logic            push;
  logic            pop;
  bptc_fifo_stat_t fifo_stat;

  logic              status;
  logic [15:0]       pressure_mbar;
  logic [6:0]        pressure_hundredths;
  logic signed [7:0] temperature_c;

  // Register access.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = bptc_reg_e'(paddr[4:2]);

  always_comb begin
    coef_d = coef_q;
    prdata = '0;
    case (reg_idx)
      RegPressSensRef: begin
        prdata = ApbDataW'(coef_q.c1);
        if (cfg_wr) coef_d.c1 = pwdata[CoefW-1:0];
      end
      RegPressOffsetRef: begin
        prdata = ApbDataW'(coef_q.c2);
        if (cfg_wr) coef_d.c2 = pwdata[CoefW-1:0];
      end
      RegSensTempCoeff: begin
        prdata = ApbDataW'(coef_q.c3);
        if (cfg_wr) coef_d.c3 = pwdata[CoefW-1:0];
      end
      RegOffsetTempCoeff: begin
        prdata = ApbDataW'(coef_q.c4);
        if (cfg_wr) coef_d.c4 = pwdata[CoefW-1:0];
      end
      RegRefTemperature: begin
        prdata = ApbDataW'(coef_q.c5);
        if (cfg_wr) coef_d.c5 = pwdata[CoefW-1:0];
      end
      RegTempCoeff: begin
        prdata = ApbDataW'(coef_q.c6);
        if (cfg_wr) coef_d.c6 = pwdata[CoefW-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  // Front: accept and classify.
  bptc_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .valid_i    (s_axis_tvalid),
    .tdata_i    (s_axis_tdata),
    .full_i     (fifo_stat.full),
    .ref_temp_i (coef_q.c5),
    .ready_o    (s_axis_tready),
    .push_o     (push),
    .item_o     (front_item)
  );

  // Queue between front and back.
  bptc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (fifo_item),
    .stat_o (fifo_stat)
  );

  // Back: compensation pipeline.
  bptc_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .coef_i                (coef_q),
    .item_valid_i          (!fifo_stat.empty),
    .item_i                (fifo_item),
    .pop_o                 (pop),
    .valid_o               (m_axis_tvalid),
    .ready_i               (m_axis_tready),
    .status_o              (status),
    .pressure_mbar_o       (pressure_mbar),
    .pressure_hundredths_o (pressure_hundredths),
    .temperature_c_o       (temperature_c)
  );

  assign m_axis_tdata = {1'b0, temperature_c, pressure_hundredths, pressure_mbar};
  assign m_axis_tuser = status;

  // An error result carries no pressure or temperature.
  `BPTC_ASSERT(a_err_zero_payload, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
  // The remainder stage never yields more than 99 hundredths.
  `BPTC_ASSERT(a_hundredths_range, m_axis_tvalid |-> (m_axis_tdata[22:16] <= 7'd99))
  // A stalled output freezes the back end, so the queue cannot drain.
  `BPTC_ASSERT_NEXT(a_stall_no_pop, m_axis_tvalid && !m_axis_tready, fifo_stat.level >= $past(fifo_stat.level))

endmodule

>>> rtl/core/bptc_front.sv
`timescale 1ns / 1ps

module bptc_front import bptc_pkg::*; #(
  parameter int unsigned ADC_BITS = 24
) (
  input  logic              valid_i,
  input  logic [2*AdcW-1:0] tdata_i,
  input  logic              full_i,
  input  logic [CoefW-1:0]  ref_temp_i,
  output logic              ready_o,
  output logic              push_o,
  output bptc_item_t        item_o
);

  localparam logic [AdcW-1:0] AdcMask = AdcW'((64'd1 << ADC_BITS) - 64'd1);

  logic [AdcW-1:0] d2;
  logic [AdcW-1:0] d1;

  // Requests are taken whenever the queue has room.
  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  // Mask the conversions to the ADC width and flag a zero reading.
  assign d2 = tdata_i[AdcW-1:0] & AdcMask;
  assign d1 = tdata_i[2*AdcW-1:AdcW] & AdcMask;

  assign item_o.zero = (d1 == '0) || (d2 == '0);
  assign item_o.d1   = d1;
  // Difference to the reference temperature, C5 scaled by 256.
  assign item_o.dt   = $signed({1'b0, d2}) - $signed({1'b0, ref_temp_i, 8'h00});

endmodule

>>> rtl/core/bptc_fifo.sv
`timescale 1ns / 1ps

module bptc_fifo import bptc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bptc_item_t      item_i,
  input  logic            pop_i,
  output bptc_item_t      item_o,
  output bptc_fifo_stat_t stat_o
);

  bptc_item_t        mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]   level_q, level_d;
  logic                do_push;
  logic                do_pop;

  assign stat_o.full  = (level_q == (FifoPtrW + 1)'(FifoDepth));
  assign stat_o.empty = (level_q == '0);
  assign stat_o.level = level_q;

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  assign wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign level_d  = level_q + (FifoPtrW + 1)'(do_push) - (FifoPtrW + 1)'(do_pop);

  assign item_o = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/bptc_back.sv
`timescale 1ns / 1ps

module bptc_back import bptc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bptc_coef_t        coef_i,
  input  logic              item_valid_i,
  input  bptc_item_t        item_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic              status_o,
  output logic [15:0]       pressure_mbar_o,
  output logic [6:0]        pressure_hundredths_o,
  output logic signed [7:0] temperature_c_o
);

  localparam int unsigned NumStages = 10;

  logic                 adv;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] zr_q;

  // Stage 1: products of dt.
  logic signed [41:0] dtc6_d, dtc6_q;
  logic signed [49:0] dtsq_d, dtsq_q;
  logic signed [41:0] c4dt_d, c4dt_q;
  logic signed [41:0] c3dt_d, c3dt_q;
  logic [AdcW-1:0]    d1_1_q, d1_2_q, d1_3_q, d1_4_q, d1_5_q;

  // Stage 2: first-order temperature, T2, offset and sensitivity bases.
  logic signed [18:0] td_d, td_q;
  logic signed [19:0] tm_d, tm_q;
  logic signed [19:0] temp_d, temp_q;
  logic               cold_d;
  logic               vcold_d;
  logic [1:0]         cold_q, vcold_q;
  logic [48:0]        dsq;
  logic [50:0]        t2a_full;
  logic [51:0]        t2b_full;
  logic [17:0]        t2_d, t2_q;
  logic signed [43:0] offb_d, offb_2_q, offb_3_q, offb_4_q;
  logic signed [43:0] sensb_d, sensb_2_q, sensb_3_q, sensb_4_q;

  // Stage 3: squares and T minus T2.
  logic signed [37:0] tdsq_full;
  logic signed [39:0] tmsq_full;
  logic [33:0]        tdsq_q, tmsq_q;
  logic signed [20:0] tt_d, tt_q;

  // Stage 4: second-order terms, temperature classification.
  logic [39:0] oa_full, sa_full;
  logic [38:0] ob_full, sb_full;
  logic [39:0] oa_q, ob_q, sa_q, sb_q;
  logic        tlo_d, thi_d, tneg_d;
  logic        tlo_q, thi_q, tneg_q;
  logic        tlo_5_q, thi_5_q, tneg_5_q;
  logic [13:0] tabs_d, tabs_q;

  // Stage 5: offset, sensitivity, temperature quotient.
  logic signed [44:0] off_d, off_5_q, off_6_q, off_7_q;
  logic signed [44:0] sens_full;
  logic signed [39:0] sens_q;
  logic [28:0]        tq_full;
  logic [6:0]         tq_q;

  // Stage 6: split product, final temperature.
  logic [43:0]        lo_d, lo_q;
  logic signed [44:0] hi_d, hi_q;
  logic signed [7:0]  tc_d;
  logic signed [7:0]  tc_6_q, tc_7_q, tc_8_q, tc_9_q;

  // Stages 7 to 9: pressure.
  logic signed [63:0] prod_d, prod_q;
  logic signed [45:0] pd;
  logic signed [45:0] ps;
  logic [22:0]        p_d, p_8_q, p_9_q;
  logic [46:0]        q_full;
  logic [15:0]        q_q;

  // Stage 10: remainder and output register.
  logic [22:0]        q100;
  logic [6:0]         rem;
  logic               status_q;
  logic [15:0]        mbar_q;
  logic [6:0]         hund_q;
  logic signed [7:0]  tc_q;

  // The whole pipeline moves unless the output holds an untaken result.
  assign adv   = !vld_q[NumStages-1] || ready_i;
  assign pop_o = adv && item_valid_i;

  // Stage 1 arithmetic.
  assign dtc6_d = 42'($signed(item_i.dt)) * 42'($signed({1'b0, coef_i.c6}));
  assign dtsq_d = 50'($signed(item_i.dt)) * 50'($signed(item_i.dt));
  assign c4dt_d = 42'($signed(item_i.dt)) * 42'($signed({1'b0, coef_i.c4}));
  assign c3dt_d = 42'($signed(item_i.dt)) * 42'($signed({1'b0, coef_i.c3}));

  // Stage 2 arithmetic: temperature below 20 C exactly when dT*C6 is negative.
  assign td_d    = 19'(dtc6_q >>> TempShift);
  assign temp_d  = 20'(td_d) + TempRef;
  assign tm_d    = temp_d + TempVeryCold;
  assign cold_d  = dtc6_q[41];
  assign vcold_d = temp_d < -TempVeryCold;
  assign dsq      = dtsq_q[48:0];
  assign t2a_full = (51'(dsq) << 1) + 51'(dsq);
  assign t2b_full = (52'(dsq) << 2) + 52'(dsq);
  assign t2_d     = cold_d ? 18'(t2a_full >> T2ColdShift) : 18'(t2b_full >> T2WarmShift);
  assign offb_d  = $signed({11'd0, coef_i.c2, 17'd0}) + 44'(c4dt_q >>> OffShift);
  assign sensb_d = $signed({12'd0, coef_i.c1, 16'd0}) + 44'(c3dt_q >>> SensShift);

  // Stage 3 arithmetic.
  assign tdsq_full = 38'(td_q) * 38'(td_q);
  assign tmsq_full = 40'(tm_q) * 40'(tm_q);
  assign tt_d      = 21'(temp_q) - $signed({3'd0, t2_q});

  // Stage 4 arithmetic: second-order terms only in the cold ranges.
  assign oa_full = 40'(tdsq_q) * 40'(Off2Mul);
  assign sa_full = 40'(tdsq_q) * 40'(Sens2Mul);
  assign ob_full = 39'(tmsq_q) * 39'(Off2ColdMul);
  assign sb_full = 39'(tmsq_q) * 39'(Sens2ColdMul);
  assign tlo_d   = tt_q <= -21'sd12800;
  assign thi_d   = tt_q >= 21'sd12700;
  assign tneg_d  = tt_q[20];
  assign tabs_d  = tneg_d ? 14'(-tt_q) : 14'(tt_q);

  // Stage 5 arithmetic.
  assign off_d     = 45'(offb_4_q) - 45'(oa_q) - 45'(ob_q);
  assign sens_full = 45'(sensb_4_q) - 45'(sa_q) - 45'(sb_q);
  assign tq_full   = 29'(tabs_q) * 29'(TempRecip);

  // Stage 6 arithmetic: D1 times SENS in two partial products.
  assign lo_d = 44'(d1_5_q) * 44'(sens_q[19:0]);
  assign hi_d = 45'($signed({1'b0, d1_5_q})) * 45'($signed(sens_q[39:20]));
  always_comb begin
    if (tlo_5_q) begin
      tc_d = -8'sd128;
    end else if (thi_5_q) begin
      tc_d = 8'sd127;
    end else if (tneg_5_q) begin
      tc_d = -$signed({1'b0, tq_q});
    end else begin
      tc_d = $signed({1'b0, tq_q});
    end
  end

  // Stage 7 arithmetic.
  assign prod_d = (64'(hi_q) <<< 20) + 64'(lo_q);

  // Stage 8 arithmetic: pressure with saturation.
  assign pd = 46'(prod_q >>> ProdShift) - 46'(off_7_q);
  assign ps = pd >>> PressShift;
  always_comb begin
    if (ps < 0) begin
      p_d = '0;
    end else if (ps > $signed(46'(PressMax))) begin
      p_d = PressMax;
    end else begin
      p_d = 23'(ps);
    end
  end

  // Stage 9 arithmetic: whole millibars.
  assign q_full = 47'(p_8_q) * 47'(PressRecip);

  // Stage 10 arithmetic: hundredths.
  assign q100 = 23'(q_q) * 23'(Hundred);
  assign rem  = 7'(p_9_q - q100);

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], item_valid_i};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zr_q <= {zr_q[NumStages-2:0], item_i.zero};
      // stage 1
      dtc6_q <= dtc6_d;
      dtsq_q <= dtsq_d;
      c4dt_q <= c4dt_d;
      c3dt_q <= c3dt_d;
      d1_1_q <= item_i.d1;
      // stage 2
      td_q      <= td_d;
      tm_q      <= tm_d;
      temp_q    <= temp_d;
      cold_q[0] <= cold_d;
      vcold_q[0] <= vcold_d;
      t2_q      <= t2_d;
      offb_2_q  <= offb_d;
      sensb_2_q <= sensb_d;
      d1_2_q    <= d1_1_q;
      // stage 3
      tdsq_q    <= tdsq_full[33:0];
      tmsq_q    <= tmsq_full[33:0];
      tt_q      <= tt_d;
      cold_q[1] <= cold_q[0];
      vcold_q[1] <= vcold_q[0];
      offb_3_q  <= offb_2_q;
      sensb_3_q <= sensb_2_q;
      d1_3_q    <= d1_2_q;
      // stage 4
      oa_q      <= cold_q[1] ? 40'(oa_full >> Off2Shift) : '0;
      sa_q      <= cold_q[1] ? 40'(sa_full >> Off2Shift) : '0;
      ob_q      <= vcold_q[1] ? 40'(ob_full) : '0;
      sb_q      <= vcold_q[1] ? 40'(sb_full) : '0;
      tlo_q     <= tlo_d;
      thi_q     <= thi_d;
      tneg_q    <= tneg_d;
      tabs_q    <= tabs_d;
      offb_4_q  <= offb_3_q;
      sensb_4_q <= sensb_3_q;
      d1_4_q    <= d1_3_q;
      // stage 5
      off_5_q  <= off_d;
      sens_q   <= sens_full[39:0];
      tq_q     <= 7'(tq_full >> TempRecipSh);
      tlo_5_q  <= tlo_q;
      thi_5_q  <= thi_q;
      tneg_5_q <= tneg_q;
      d1_5_q   <= d1_4_q;
      // stage 6
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      tc_6_q  <= tc_d;
      off_6_q <= off_5_q;
      // stage 7
      prod_q  <= prod_d;
      tc_7_q  <= tc_6_q;
      off_7_q <= off_6_q;
      // stage 8
      p_8_q  <= p_d;
      tc_8_q <= tc_7_q;
      // stage 9
      q_q    <= 16'(q_full >> PressRecipSh);
      p_9_q  <= p_8_q;
      tc_9_q <= tc_8_q;
      // stage 10: a zero reading clears the result fields
      status_q <= zr_q[NumStages-2];
      mbar_q   <= zr_q[NumStages-2] ? '0 : q_q;
      hund_q   <= zr_q[NumStages-2] ? '0 : rem;
      tc_q     <= zr_q[NumStages-2] ? '0 : tc_9_q;
    end
  end

  assign valid_o               = vld_q[NumStages-1];
  assign status_o              = status_q;
  assign pressure_mbar_o       = mbar_q;
  assign pressure_hundredths_o = hund_q;
  assign temperature_c_o       = tc_q;

endmodule

>>> verif/tb_baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation;
  import bptc_pkg::*;

  // Indexes beyond the register map; writes there must have no effect.
  localparam logic [2:0] RegUnmappedLo = 3'd6;
  localparam logic [2:0] RegUnmappedHi = 3'd7;

  localparam longint AdcMax        = 64'sd16777215;
  localparam longint PressSatLimit = 64'sd6553599;
  localparam int     WatchdogLimit = 4000;
  localparam int     SettleCycles  = 30;

  // Typical calibration of a production part, word 0 in the low bits.
  localparam logic [5:0][15:0] TypicalCal = {16'd28165, 16'd31553, 16'd27842,
                                             16'd29059, 16'd43981, 16'd46372};

  typedef struct packed {
    logic              status;
    logic [15:0]       mbar;
    logic [6:0]        hundredths;
    logic signed [7:0] temp_c;
  } reading_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata = '0;  // [23:0] temp_adc, [47:24] press_adc
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;       // [15:0] pressure_mbar,
                                           // [22:16] pressure_hundredths,
                                           // [30:23] temperature_c, [31] constant 0
  logic                m_axis_tuser;       // [0] status

  // Shadow copy of the calibration words C1..C6.
  logic [15:0] cal_word [0:5];

  reading_t pending_readings [$];
  int       mismatch_count = 0;
  int       samples_sent = 0;
  int       readings_checked = 0;
  int       cal_settings = 0;
  int       quiet_cycles = 0;
  int       src_gap_pct = 0;
  int       sink_stall_pct = 0;

  baro_pressure_temp_compensation i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver backpressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compensated reading for one raw sample pair under the current calibration.
  function automatic reading_t compensate_sample(input logic [23:0] temp_raw,
                                                 input logic [23:0] press_raw);
    reading_t r;
    longint   d1, d2, dt, temp, t2, off2, sens2, off, sens, p, tc, td, tm;
    r = '0;
    d2 = longint'(temp_raw);
    d1 = longint'(press_raw);
    if (d1 == 0 || d2 == 0) begin
      r.status = 1'b1;
      return r;
    end
    dt = d2 - longint'({cal_word[RegRefTemperature], 8'h00});
    temp = 2000 + ((dt * longint'(cal_word[RegTempCoeff])) >>> 23);
    off2 = 0;
    sens2 = 0;
    if (temp < 2000) begin
      td = temp - 2000;
      t2 = (3 * dt * dt) >>> 33;
      off2 = 61 * td * td / 16;
      sens2 = 29 * td * td / 16;
      // Extra correction in the very cold range.
      if (temp < -1500) begin
        tm = temp + 1500;
        off2 += 17 * tm * tm;
        sens2 += 9 * tm * tm;
      end
    end else begin
      t2 = (5 * dt * dt) >>> 38;
    end
    off = (longint'(cal_word[RegPressOffsetRef]) <<< 17)
        + ((longint'(cal_word[RegOffsetTempCoeff]) * dt) >>> 6) - off2;
    sens = (longint'(cal_word[RegPressSensRef]) <<< 16)
         + ((longint'(cal_word[RegSensTempCoeff]) * dt) >>> 7) - sens2;
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p < 0) p = 0;
    if (p > PressSatLimit) p = PressSatLimit;
    // Division truncates toward zero before the temperature is clamped.
    tc = (temp - t2) / 100;
    if (tc < -128) tc = -128;
    if (tc > 127) tc = 127;
    r.mbar = 16'(p / 100);
    r.hundredths = 7'(p % 100);
    r.temp_c = 8'(tc);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Record each accepted request and check each delivered result.
  always @(posedge clk_i) begin : result_check
    reading_t got, want;
    if (rst_ni) begin
      quiet_cycles++;
      if (psel && penable && pready) quiet_cycles = 0;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_readings.push_back(compensate_sample(s_axis_tdata[23:0],
                                                     s_axis_tdata[47:24]));
        samples_sent++;
        quiet_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        got.status = m_axis_tuser;
        got.mbar = m_axis_tdata[15:0];
        got.hundredths = m_axis_tdata[22:16];
        got.temp_c = m_axis_tdata[30:23];
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h/%b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          want = pending_readings.pop_front();
          readings_checked++;
          check_field("status", want.status, got.status);
          check_field("pressure_mbar", want.mbar, got.mbar);
          check_field("pressure_hundredths", want.hundredths, got.hundredths);
          check_field("temperature_c", want.temp_c, got.temp_c);
        end
      end
    end
  end

  // Ends the run when nothing moves for too long.
  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, WatchdogLimit, pending_readings.size());
    $display("tb_baro_pressure_temp_compensation: done, errors");
    $finish;
  end

  task automatic apb_write(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    // Upper data bits are junk; the registers are 16 bits wide.
    pwdata <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= RegTempCoeff) cal_word[idx] = value;
  endtask

  task automatic apb_read_check(input logic [2:0] idx);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0000, cal_word[idx]}) begin
      $display("%0t: register %0d readback mismatch, expected %h, actual %h",
               $time, idx, {16'h0000, cal_word[idx]}, prdata);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_calibration(input logic [5:0][15:0] words);
    for (int i = 0; i <= RegTempCoeff; i++) apb_write(3'(i), words[i]);
    cal_settings++;
  endtask

  // One request; the valid stays high across back-to-back requests.
  task automatic send_sample(input logic [23:0] temp_raw, input logic [23:0] press_raw);
    if ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {press_raw, temp_raw};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and let every outstanding result come back. The first edge
  // makes sure the last accepted request has been recorded.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_edge_value();
    case ($urandom_range(3))
      0: return 24'd1;
      1: return 24'hFFFFFF;
      2: return 24'h800000;
      default: return 24'h7FFFFF;
    endcase
  endfunction

  // Temperature conversions cluster around the reference point so that the
  // warm, cold and very cold branches are all reached.
  function automatic logic [23:0] pick_temp_raw();
    int unsigned sel;
    longint      centre, span, v;
    sel = $urandom_range(99);
    if (sel < 5) return 24'd0;
    if (sel < 20) return 24'($urandom);
    if (sel < 30) return pick_edge_value();
    centre = longint'({cal_word[RegRefTemperature], 8'h00});
    span = longint'($urandom_range(0, (1 << $urandom_range(4, 23)) - 1));
    v = ($urandom_range(1) != 0) ? centre + span : centre - span;
    if (v < 1) v = 1;
    if (v > AdcMax) v = AdcMax;
    return 24'(v);
  endfunction

  function automatic logic [23:0] pick_press_raw();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return 24'd0;
    if (sel < 25) return 24'($urandom);
    if (sel < 35) return pick_edge_value();
    return 24'($urandom_range(4000000, 9000000));
  endfunction

  // Register map: write, read back, and ignore writes past the last register.
  task automatic test_register_access();
    load_calibration({16'hFFFF, 16'h0001, 16'hA5A5, 16'h5A5A, 16'h8000, 16'h7FFF});
    for (int i = 0; i <= RegTempCoeff; i++) apb_read_check(3'(i));
    apb_write(RegUnmappedLo, 16'hDEAD);
    apb_write(RegUnmappedHi, 16'hBEEF);
    for (int i = 0; i <= RegTempCoeff; i++) apb_read_check(3'(i));
  endtask

  // Typical samples, zero conversions and the raw field extremes.
  task automatic test_zero_and_extremes();
    load_calibration(TypicalCal);
    send_sample(24'd8077636, 24'd6465444);
    send_sample(24'd0, 24'd6465444);
    send_sample(24'd8077636, 24'd0);
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'd1, 24'd1);
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h555555, 24'hAAAAAA);
    wait_drained();
  endtask

  // Warm, cold, very cold and both temperature clamps.
  task automatic test_temperature_regions();
    send_sample(24'd8077568, 24'd6465444);
    send_sample(24'd7577568, 24'd6465444);
    send_sample(24'd6077568, 24'd6465444);
    send_sample(24'd1, 24'd6465444);
    send_sample(24'hFFFFFF, 24'd6465444);
    wait_drained();
  endtask

  // Negative pressure and pressure overflow, plus the calibration extremes.
  task automatic test_pressure_saturation();
    send_sample(24'd8077636, 24'd1);
    wait_drained();
    load_calibration({16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_sample(24'd1, 24'd1);
    send_sample(24'd2, 24'd3);
    wait_drained();
    load_calibration({6{16'hFFFF}});
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'd1, 24'hFFFFFF);
    wait_drained();
    load_calibration('0);
    send_sample(24'd8077636, 24'd6465444);
    wait_drained();
  endtask

  // Random samples under a jittered typical calibration and a random one.
  task automatic test_random_samples(input int gap_pct, input int stall_pct,
                                     input int n_items);
    logic [5:0][15:0] words;
    src_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < 6; i++) words[i] = TypicalCal[i] ^ 16'($urandom_range(0, 4095));
    load_calibration(words);
    repeat (n_items / 2) send_sample(pick_temp_raw(), pick_press_raw());
    wait_drained();
    for (int i = 0; i < 6; i++) words[i] = 16'($urandom);
    load_calibration(words);
    repeat (n_items - n_items / 2) send_sample(pick_temp_raw(), pick_press_raw());
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i <= RegTempCoeff; i++) cal_word[i] = 16'h0000;
    repeat (2) @(posedge clk_i);

    sink_stall_pct = 30;
    test_register_access();
    test_zero_and_extremes();
    test_temperature_regions();
    test_pressure_saturation();
    test_random_samples(7, 60, 234);
    test_random_samples(60, 7, 234);
    test_random_samples(0, 0, 234);

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d sample pairs and checked %0d readings under %0d calibration settings,",
             samples_sent, readings_checked, cal_settings);
    $display("with zero conversions, cold branches, clamps and both backpressure mixes.");
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("tb_baro_pressure_temp_compensation: done, clean");
    end else begin
      $display("tb_baro_pressure_temp_compensation: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bptc_pkg.sv
rtl/core/bptc_front.sv
rtl/core/bptc_fifo.sv
rtl/core/bptc_back.sv
rtl/core/baro_pressure_temp_compensation.sv
verif/tb_baro_pressure_temp_compensation.sv
